[rtl/tag_bracket_expander_core_assert.svh]
// ----------------------------------------------------------------------------
// Tag bracket expander assertion macros
// Shared assertion forms for the checker of the tag bracket expander.
// ----------------------------------------------------------------------------
`ifndef TAG_BRACKET_EXPANDER_CORE_ASSERT_SVH
`define TAG_BRACKET_EXPANDER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TBX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TBX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tbx_pkg.sv]
// ----------------------------------------------------------------------------
// Tag bracket expander package
// Widths, status and register codes, and the types shared by the expander.
// ----------------------------------------------------------------------------
package tbx_pkg;

  localparam int DEF_STACK_DEPTH = 32;
  localparam int DEF_TAG_WIDTH   = 16;

  localparam int TYPE_W     = 8;
  localparam int OFS_W      = 17;
  localparam int LEN_W      = 16;
  localparam int TAGIN_W    = 16;
  localparam int MARK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_OPEN  = 2'd1;
  localparam logic [1:0] ST_UNCLOSED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LPAREN_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RPAREN_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_CODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MARK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MARK  = 3'd6;

  typedef struct packed {
    logic [TYPE_W-1:0] open_code;
    logic [TYPE_W-1:0] close_code;
    logic [TYPE_W-1:0] lparen_code;
    logic [TYPE_W-1:0] rparen_code;
    logic [TYPE_W-1:0] symbol_code;
    logic [MARK_W-1:0] left_mark;
    logic [MARK_W-1:0] right_mark;
  } tbx_cfg_t;

  // one classified token; for a bracket, tok_type is the paren code,
  // ofs the tag and len the mark of the symbol
  typedef struct packed {
    logic              expand;
    logic [TYPE_W-1:0] tok_type;
    logic [OFS_W-1:0]  ofs;
    logic [LEN_W-1:0]  len;
    logic [1:0]        status;
    logic              last;
  } tbx_entry_t;

endpackage

[rtl/tag_bracket_expander_core.sv]
// ----------------------------------------------------------------------------
// Tag bracket expander core
// Rewrites tagged brackets of a token stream into paren/symbol/paren runs.
// ----------------------------------------------------------------------------
// Ordinary tokens stream at one per clock while the output is ready; a tagged
// open or close bracket becomes three results, which leave the output
// register one after another before the back end takes the next queued
// token. The output register of the back end paces the stream; a two-entry
// queue between front and back lets the front keep taking tokens
// while results wait. The tag stack keeps its top in a register and the
// entries below it in a memory whose next entry is prefetched each cycle, so
// pushes and pops run back to back. Status reports close without open,
// unclosed at end and overflow on every result of the token that raised it.
// No clearing pass: the block is ready right after reset. Configuration
// writes are always taken and belong only in idle periods.
module tag_bracket_expander_core
  import tbx_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int TAG_WIDTH   = DEF_TAG_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TYPE_W-1:0]       in_token_type,
  input  logic signed [OFS_W-1:0] in_token_offset,
  input  logic [LEN_W-1:0]        in_token_length,
  input  logic [TAGIN_W-1:0]      in_tag_number,
  input  logic                    in_last_token,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TYPE_W-1:0]       out_type,
  output logic signed [OFS_W-1:0] out_offset,
  output logic [LEN_W-1:0]        out_length,
  output logic [1:0]              out_status,
  output logic                    out_run_end,
  output logic                    out_list_end,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  tbx_cfg_t   cfg_r;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  tbx_entry_t q_din;
  tbx_entry_t q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_code   <= TYPE_W'(0);
      cfg_r.close_code  <= TYPE_W'(1);
      cfg_r.lparen_code <= TYPE_W'(2);
      cfg_r.rparen_code <= TYPE_W'(3);
      cfg_r.symbol_code <= TYPE_W'(4);
      cfg_r.left_mark   <= MARK_W'(0);
      cfg_r.right_mark  <= MARK_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OPEN_CODE:   cfg_r.open_code   <= cfg_data[TYPE_W-1:0];
        REG_CLOSE_CODE:  cfg_r.close_code  <= cfg_data[TYPE_W-1:0];
        REG_LPAREN_CODE: cfg_r.lparen_code <= cfg_data[TYPE_W-1:0];
        REG_RPAREN_CODE: cfg_r.rparen_code <= cfg_data[TYPE_W-1:0];
        REG_SYMBOL_CODE: cfg_r.symbol_code <= cfg_data[TYPE_W-1:0];
        REG_LEFT_MARK:   cfg_r.left_mark   <= cfg_data[MARK_W-1:0];
        REG_RIGHT_MARK:  cfg_r.right_mark  <= cfg_data[MARK_W-1:0];
        default: begin
          // index beyond the register list: drop the write
        end
      endcase
    end
  end

  tbx_front #(
    .STACK_DEPTH (STACK_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_token_type   (in_token_type),
    .in_token_offset (in_token_offset),
    .in_token_length (in_token_length),
    .in_tag_number   (in_tag_number),
    .in_last_token   (in_last_token),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_din)
  );

  tbx_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_dout),
    .pop   (q_pop)
  );

  tbx_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .symbol_code  (cfg_r.symbol_code),
    .q_valid      (q_valid),
    .q_entry      (q_dout),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_type     (out_type),
    .out_offset   (out_offset),
    .out_length   (out_length),
    .out_status   (out_status),
    .out_run_end  (out_run_end),
    .out_list_end (out_list_end)
  );

endmodule

[rtl/tbx_queue.sv]
// ----------------------------------------------------------------------------
// Tag bracket expander queue
// Short FIFO of classified tokens between the front and the back.
// ----------------------------------------------------------------------------
module tbx_queue
  import tbx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tbx_entry_t din,
  output logic       full,
  output logic       valid,
  output tbx_entry_t dout,
  input  logic       pop
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  tbx_entry_t       slots [QUEUE_DEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign valid = (count_r != '0);
  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign dout  = slots[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/tbx_front.sv]
// ----------------------------------------------------------------------------
// Tag bracket expander front
// Accepts tokens, classifies them and keeps the tag stack.
// ----------------------------------------------------------------------------
module tbx_front
  import tbx_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int TAG_WIDTH   = DEF_TAG_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tbx_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TYPE_W-1:0]  in_token_type,
  input  logic [OFS_W-1:0]   in_token_offset,
  input  logic [LEN_W-1:0]   in_token_length,
  input  logic [TAGIN_W-1:0] in_tag_number,
  input  logic               in_last_token,
  input  logic               q_full,
  output logic               q_push,
  output tbx_entry_t         q_entry
);

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // top of stack lives in top_r; entries below it live in stack_mem
  logic [TAG_WIDTH-1:0] stack_mem [STACK_DEPTH];
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [TAG_WIDTH-1:0] top_r, top_nxt;
  logic [TAG_WIDTH-1:0] rd_r;
  logic                 byp_r;
  logic [TAG_WIDTH-1:0] byp_data_r;
  logic [TAG_WIDTH-1:0] top_below;
  logic [TAG_WIDTH-1:0] tag_in;
  logic                 wr_en;
  logic [AW-1:0]        waddr, raddr;
  logic                 accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;
  assign tag_in    = TAG_WIDTH'(in_tag_number);
  assign top_below = byp_r ? byp_data_r : rd_r;
  assign waddr     = AW'(fill_r - 1'b1);
  // prefetch the entry that becomes the top after the next pop
  assign raddr     = AW'(fill_nxt - FW'(2));

  always_comb begin
    fill_nxt         = fill_r;
    top_nxt          = top_r;
    wr_en            = 1'b0;
    q_entry.expand   = 1'b0;
    q_entry.tok_type = in_token_type;
    q_entry.ofs      = in_token_offset;
    q_entry.len      = in_token_length;
    q_entry.status   = ST_OK;
    q_entry.last     = in_last_token;
    if (accept) begin
      if (in_token_type == cfg.open_code) begin
        q_entry.expand   = 1'b1;
        q_entry.tok_type = cfg.lparen_code;
        q_entry.ofs      = OFS_W'(tag_in);
        q_entry.len      = cfg.left_mark;
        if (fill_r == FW'(STACK_DEPTH)) begin
          q_entry.status = ST_OVERFLOW;
        end else begin
          wr_en    = (fill_r != '0);
          top_nxt  = tag_in;
          fill_nxt = fill_r + 1'b1;
        end
      end else if (in_token_type == cfg.close_code) begin
        q_entry.expand   = 1'b1;
        q_entry.tok_type = cfg.rparen_code;
        q_entry.len      = cfg.right_mark;
        if (fill_r == '0) begin
          q_entry.status = ST_NO_OPEN;
          q_entry.ofs    = '0;
        end else begin
          q_entry.ofs = OFS_W'(top_r);
          fill_nxt    = fill_r - 1'b1;
          top_nxt     = top_below;
        end
      end
      // drop whatever is left open at the end of the list
      if (in_last_token && fill_nxt != '0) begin
        fill_nxt = '0;
        if (q_entry.status == ST_OK) begin
          q_entry.status = ST_UNCLOSED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[waddr] <= top_r;
    end
    rd_r       <= stack_mem[raddr];
    byp_r      <= wr_en && (waddr == raddr);
    byp_data_r <= top_r;
    top_r      <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

[rtl/tbx_back.sv]
// ----------------------------------------------------------------------------
// Tag bracket expander back
// Expands queued tokens into result tokens through the output register.
// ----------------------------------------------------------------------------
module tbx_back
  import tbx_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [TYPE_W-1:0]   symbol_code,
  input  logic                q_valid,
  input  tbx_entry_t          q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TYPE_W-1:0]   out_type,
  output logic signed [OFS_W-1:0] out_offset,
  output logic [LEN_W-1:0]    out_length,
  output logic [1:0]          out_status,
  output logic                out_run_end,
  output logic                out_list_end
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SYM,
    PH_LAST
  } phase_t;

  phase_t            phase_r;
  logic              out_valid_r;
  logic [TYPE_W-1:0] type_r;
  logic [OFS_W-1:0]  ofs_r;
  logic [LEN_W-1:0]  len_r;
  logic [1:0]        status_r;
  logic              run_end_r;
  logic              list_end_r;
  logic              load;

  assign load  = !out_valid_r || out_ready;
  assign q_pop = load && q_valid && (!q_entry.expand || phase_r == PH_LAST);

  assign out_valid    = out_valid_r;
  assign out_type     = type_r;
  assign out_offset   = ofs_r;
  assign out_length   = len_r;
  assign out_status   = status_r;
  assign out_run_end  = run_end_r;
  assign out_list_end = list_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= q_valid;
      if (q_valid) begin
        status_r <= q_entry.status;
        if (!q_entry.expand) begin
          type_r     <= q_entry.tok_type;
          ofs_r      <= q_entry.ofs;
          len_r      <= q_entry.len;
          run_end_r  <= 1'b1;
          list_end_r <= q_entry.last;
        end else begin
          unique case (phase_r)
            PH_FIRST: begin
              type_r     <= q_entry.tok_type;
              ofs_r      <= '1;
              len_r      <= '0;
              run_end_r  <= 1'b0;
              list_end_r <= 1'b0;
              phase_r    <= PH_SYM;
            end
            PH_SYM: begin
              type_r     <= symbol_code;
              ofs_r      <= q_entry.ofs;
              len_r      <= q_entry.len;
              run_end_r  <= 1'b0;
              list_end_r <= 1'b0;
              phase_r    <= PH_LAST;
            end
            PH_LAST: begin
              type_r     <= q_entry.tok_type;
              ofs_r      <= '1;
              len_r      <= '0;
              run_end_r  <= 1'b1;
              list_end_r <= q_entry.last;
              phase_r    <= PH_FIRST;
            end
            default: begin
              phase_r <= PH_FIRST;
            end
          endcase
        end
      end
    end
  end

endmodule

[rtl/tbx_checker.sv]
// ----------------------------------------------------------------------------
// Tag bracket expander checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "tag_bracket_expander_core_assert.svh"

module tbx_checker
  import tbx_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [TYPE_W-1:0]       out_type,
  input logic signed [OFS_W-1:0] out_offset,
  input logic [LEN_W-1:0]        out_length,
  input logic [1:0]              out_status,
  input logic                    out_run_end,
  input logic                    out_list_end
);

  // a stalled result holds
  `TBX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_type) && $stable(out_offset) && $stable(out_length) && $stable(out_status), "stalled result changed")

  // the end of the list is always the end of a run
  `TBX_ASSERT_SAME(a_list_end_run, clk, rst_n, out_valid && out_list_end, out_run_end, "list end without run end")

  // all results of one token carry the same status
  `TBX_ASSERT_NEXT(a_status_run, clk, rst_n, out_valid && out_ready && !out_run_end, !out_valid || out_status == $past(out_status), "status changed within a run")

  // a run in progress keeps the output busy in the next cycle
  `TBX_ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && out_ready && !out_run_end, out_valid, "run broken off")

endmodule

bind tag_bracket_expander_core tbx_checker u_tbx_checker (.*);
